// ===== rtl/pcfc_pkg.sv =====
package pcfc_pkg;

	// Register reset values
	localparam logic [7:0] HEADER_BYTE_RST  = 8'hFE;
	localparam logic [7:0] COMMAND_CODE_RST = 8'h03;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_CODE = 1'd1;

	// CRC-16/MODBUS
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Frame constants
	localparam logic [7:0] MIN_LEN    = 8'd4;
	localparam logic [7:0] BODY_START = 8'd4;
	localparam logic [7:0] STATUS_OFF = 8'd0;
	localparam logic [7:0] STATUS_ON  = 8'd1;

	// Reply codes
	localparam logic REPLY_OK  = 1'b0;
	localparam logic REPLY_ERR = 1'b1;

	// Command queue depth default
	localparam int QUEUE_DEPTH_DEF = 2;

	// Checked power command handed from parser to executor
	typedef struct packed {
		logic turn_on;   // 1: power on request, 0: power off request
		logic good;      // power_good sampled with the last CRC byte
	} cmd_t;

	// One byte through the reflected CRC, bit at a time
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int n = 0; n < 8; n++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/pcfc_front.sv =====
module pcfc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          header_byte,
	input  logic [7:0]          command_code,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	input  logic                power_good,
	input  logic                q_full,
	output logic                q_push,
	output pcfc_pkg::cmd_t      q_data
);
	import pcfc_pkg::*;

	typedef enum logic [6:0] {
		PH_HDR1 = 7'b0000001,
		PH_HDR2 = 7'b0000010,
		PH_LEN  = 7'b0000100,
		PH_CMD  = 7'b0001000,
		PH_BODY = 7'b0010000,
		PH_CRCH = 7'b0100000,
		PH_CRCL = 7'b1000000
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  byte_index_q;
	logic [7:0]  frame_length_q;
	logic [7:0]  status_q;
	logic [15:0] crc_q;
	logic [7:0]  crc_first_q;

	logic        accept;
	logic        crc_match;
	logic [15:0] crc_in;
	logic [15:0] crc_nx;

	// Stall only when the command queue has no room
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Single CRC update unit; a new frame restarts from the init value
	assign crc_in = (phase_q == PH_HDR1) ? CRC_INIT : crc_q;
	assign crc_nx = crc_feed(crc_in, rx_byte);

	assign crc_match = (crc_first_q == crc_q[15:8]) && (rx_byte == crc_q[7:0]);

	// Hand a checked on/off command to the executor
	assign q_push       = accept && (phase_q == PH_CRCL) && crc_match &&
	                      ((status_q == STATUS_ON) || (status_q == STATUS_OFF));
	assign q_data.turn_on = status_q[0];
	assign q_data.good    = power_good;

	// Frame parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HDR1;
			byte_index_q   <= '0;
			frame_length_q <= '0;
			status_q       <= '0;
			crc_q          <= CRC_INIT;
			crc_first_q    <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_HDR2: begin
					if (rx_byte == header_byte) begin
						crc_q   <= crc_nx;
						phase_q <= PH_LEN;
					end else begin
						phase_q <= PH_HDR1;
					end
				end
				PH_LEN: begin
					frame_length_q <= rx_byte;
					if (rx_byte < MIN_LEN) begin
						phase_q <= PH_HDR1;
					end else begin
						crc_q   <= crc_nx;
						phase_q <= PH_CMD;
					end
				end
				PH_CMD: begin
					if (rx_byte == command_code) begin
						crc_q        <= crc_nx;
						byte_index_q <= BODY_START;
						phase_q      <= PH_BODY;
					end else begin
						phase_q <= PH_HDR1;
					end
				end
				PH_BODY: begin
					if (byte_index_q == BODY_START) begin
						status_q <= rx_byte;
					end
					crc_q <= crc_nx;
					if (byte_index_q == frame_length_q) begin
						phase_q <= PH_CRCH;
					end else begin
						byte_index_q <= byte_index_q + 8'd1;
					end
				end
				PH_CRCH: begin
					crc_first_q <= rx_byte;
					phase_q     <= PH_CRCL;
				end
				PH_CRCL: begin
					phase_q <= PH_HDR1;
				end
				default: begin
					// hunting the first header byte
					if (rx_byte == header_byte) begin
						crc_q        <= crc_nx;
						byte_index_q <= '0;
						phase_q      <= PH_HDR2;
					end else begin
						phase_q <= PH_HDR1;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/pcfc_cmd_queue.sv =====
module pcfc_cmd_queue #(
	parameter int DEPTH = pcfc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pcfc_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output pcfc_pkg::cmd_t pop_data,
	output logic           empty
);
	import pcfc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/pcfc_back.sv =====
module pcfc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  pcfc_pkg::cmd_t q_data,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           reply_code,
	output logic           power_enable
);
	import pcfc_pkg::*;

	logic powered_q;
	logic enable_q;
	logic out_valid_q;
	logic reply_q;
	logic out_enable_q;

	// Take a command when the output word is free or leaving
	assign q_pop = !q_empty && (!out_valid_q || !out_stall);

	assign out_valid    = out_valid_q;
	assign reply_code   = reply_q;
	assign power_enable = out_enable_q;

	// Power state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			powered_q    <= 1'b0;
			enable_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			reply_q      <= REPLY_OK;
			out_enable_q <= 1'b0;
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
				if (q_data.turn_on) begin
					if (powered_q) begin
						// already on: enable level unchanged
						reply_q      <= REPLY_OK;
						out_enable_q <= enable_q;
					end else begin
						enable_q     <= 1'b1;
						powered_q    <= q_data.good;
						reply_q      <= q_data.good ? REPLY_OK : REPLY_ERR;
						out_enable_q <= 1'b1;
					end
				end else begin
					enable_q     <= 1'b0;
					powered_q    <= 1'b0;
					reply_q      <= REPLY_ERR;
					out_enable_q <= 1'b0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/power_command_frame_checker_unit.sv =====
// Power command frame checker: parser, command queue and power executor.
// Throughput: one byte per cycle; the parser stalls only when the command queue is full.
// Reply path: the edge taking the low CRC byte writes the queue; the executor then loads the output
// register from the queue once the output word is free or leaving.
// Reset (arst_n low, asynchronous): parser hunts for a header, CRC at FFFF, power off,
// queue and output empty, registers back to header FE and command 03.
module power_command_frame_checker_unit #(
	parameter int QUEUE_DEPTH = pcfc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pcfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       rx_byte,
	input  logic                             power_good,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             reply_code,
	output logic                             power_enable
);
	import pcfc_pkg::*;

	logic [7:0] header_byte_q;
	logic [7:0] command_code_q;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	cmd_t q_wdata;
	cmd_t q_rdata;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_byte_q  <= HEADER_BYTE_RST;
			command_code_q <= COMMAND_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HEADER_BYTE:  header_byte_q  <= cfg_data;
				REG_COMMAND_CODE: command_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pcfc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.header_byte  (header_byte_q),
		.command_code (command_code_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.power_good   (power_good),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	pcfc_cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	pcfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.reply_code   (reply_code),
		.power_enable (power_enable)
	);

endmodule
